// ===== src/csv_code_point_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// csv_code_point_tokenizer_macros
// Assertion macros for the CSV code point tokenizer.
// ----------------------------------------------------------------------------
`ifndef CSV_CODE_POINT_TOKENIZER_MACROS_SVH
`define CSV_CODE_POINT_TOKENIZER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CSV_TOK_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CSV_TOK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/csv_tok_pkg.sv =====
// ----------------------------------------------------------------------------
// csv_tok_pkg
// Types, codes and character decode helpers of the CSV tokenizer.
// ----------------------------------------------------------------------------
package csv_tok_pkg;

	localparam int CP_W   = 21;
	localparam int KIND_W = 3;
	localparam int MODE_W = 3;
	localparam int ACC_W  = 16;
	localparam int HCNT_W = 3;
	localparam int NRES_W = 2;

	localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LITERAL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STRING  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ESCAPE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HEX     = 3'd4;
	localparam logic [MODE_W-1:0] MODE_SEP     = 3'd5;
	localparam logic [MODE_W-1:0] MODE_EOL     = 3'd6;
	localparam logic [MODE_W-1:0] MODE_ERROR   = 3'd7;

	localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SEP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EOL   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

	localparam logic [CP_W-1:0] SEP_RESET = 21'd44;

	localparam logic [CP_W-1:0] CH_BS_CTL = 21'd8;
	localparam logic [CP_W-1:0] CH_TAB    = 21'd9;
	localparam logic [CP_W-1:0] CH_LF     = 21'd10;
	localparam logic [CP_W-1:0] CH_FF     = 21'd12;
	localparam logic [CP_W-1:0] CH_CR     = 21'd13;
	localparam logic [CP_W-1:0] CH_SPACE  = 21'd32;
	localparam logic [CP_W-1:0] CH_DQUOTE = 21'd34;
	localparam logic [CP_W-1:0] CH_SQUOTE = 21'd39;
	localparam logic [CP_W-1:0] CH_COMMA  = 21'd44;
	localparam logic [CP_W-1:0] CH_SLASH  = 21'd47;
	localparam logic [CP_W-1:0] CH_COLON  = 21'd58;
	localparam logic [CP_W-1:0] CH_LBRACK = 21'd91;
	localparam logic [CP_W-1:0] CH_BSLASH = 21'd92;
	localparam logic [CP_W-1:0] CH_RBRACK = 21'd93;
	localparam logic [CP_W-1:0] CH_LBRACE = 21'd123;
	localparam logic [CP_W-1:0] CH_RBRACE = 21'd125;
	localparam logic [CP_W-1:0] CH_B      = 21'd98;
	localparam logic [CP_W-1:0] CH_F      = 21'd102;
	localparam logic [CP_W-1:0] CH_N      = 21'd110;
	localparam logic [CP_W-1:0] CH_R      = 21'd114;
	localparam logic [CP_W-1:0] CH_T      = 21'd116;
	localparam logic [CP_W-1:0] CH_U      = 21'd117;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CP_W-1:0]   value;
		logic              last;
	} tok_res_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ACC_W-1:0]  acc;
		logic [HCNT_W-1:0] hcnt;
		logic [NRES_W-1:0] nres;
		tok_res_t          r0;
		tok_res_t          r1;
	} step_res_t;

	typedef struct packed {
		logic              emit;
		logic [KIND_W-1:0] kind;
		logic [MODE_W-1:0] mode;
	} start_res_t;

	function automatic logic is_eol(input logic [CP_W-1:0] cp);
		return (cp == CH_LF) || (cp == CH_CR);
	endfunction

	function automatic logic is_lit_term(input logic [CP_W-1:0] cp);
		return is_eol(cp) || (cp == CH_DQUOTE) || (cp == CH_SQUOTE) ||
			(cp == CH_LBRACK) || (cp == CH_RBRACK) || (cp == CH_LBRACE) ||
			(cp == CH_RBRACE) || (cp == CH_COMMA) || (cp == CH_COLON);
	endfunction

	// bit 4 flags a valid digit, bits 3:0 carry its value
	function automatic logic [4:0] hex_digit(input logic [CP_W-1:0] cp);
		logic [4:0] r;
		r = 5'd0;
		if (cp >= 21'd48 && cp <= 21'd57)
			r = {1'b1, 4'(cp - 21'd48)};
		else if (cp >= 21'd97 && cp <= 21'd102)
			r = {1'b1, 4'(cp - 21'd87)};
		else if (cp >= 21'd65 && cp <= 21'd70)
			r = {1'b1, 4'(cp - 21'd55)};
		return r;
	endfunction

	// start-mode handling; any emitted word carries the code point itself
	function automatic start_res_t start_step(input logic [CP_W-1:0] cp,
			input logic [CP_W-1:0] sep);
		start_res_t r;
		r = '{emit: 1'b0, kind: KIND_CHAR, mode: MODE_START};
		if (cp == sep) begin
			r = '{emit: 1'b1, kind: KIND_SEP, mode: MODE_SEP};
		end else if (cp == CH_SPACE || cp == CH_TAB) begin
			r = '{emit: 1'b0, kind: KIND_CHAR, mode: MODE_START};
		end else if (is_eol(cp)) begin
			r = '{emit: 1'b1, kind: KIND_EOL, mode: MODE_EOL};
		end else if (cp == CH_DQUOTE) begin
			r = '{emit: 1'b0, kind: KIND_CHAR, mode: MODE_STRING};
		end else begin
			r = '{emit: 1'b1, kind: KIND_CHAR, mode: MODE_LITERAL};
		end
		return r;
	endfunction

endpackage

// ===== src/csv_code_point_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_code_point_tokenizer
// Streaming CSV tokenizer over Unicode code points with string escapes.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// cp       in         cp_valid/cp_stall    code_point
// tok      out        tok_valid/tok_stall  token_kind, char_value, last_of_run
// cfg      in         cfg_valid/cfg_ready  separator_char
//
// A code point is registered, decoded in the next cycle and its words land in
// a two-entry result buffer: one code point per cycle while cp_stall is low,
// and a code point that gives two words sends them one after the other.
// Reset leaves start mode, separator comma and an empty buffer.
// cp_stall rises while the decoded code point finds no room in the buffer.
// ----------------------------------------------------------------------------
`include "csv_code_point_tokenizer_macros.svh"

module csv_code_point_tokenizer import csv_tok_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cp_valid,
	output logic              cp_stall,
	input  logic [CP_W-1:0]   code_point,
	output logic              tok_valid,
	input  logic              tok_stall,
	output logic [KIND_W-1:0] token_kind,
	output logic [CP_W-1:0]   char_value,
	output logic              last_of_run,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CP_W-1:0]   separator_char
);

	logic              vld_s1;
	logic [CP_W-1:0]   cp_s1;
	logic [CP_W-1:0]   sep_q;
	logic [MODE_W-1:0] mode_q;
	logic [ACC_W-1:0]  acc_q;
	logic [HCNT_W-1:0] hcnt_q;
	step_res_t         step;
	logic [NRES_W-1:0] room;
	logic              proc;
	logic              take;
	tok_res_t          head;

	assign cfg_ready = 1'b1;
	assign proc      = vld_s1 && (room >= step.nres);
	assign cp_stall  = vld_s1 && !proc;
	assign take      = cp_valid && !cp_stall;

	csv_tok_step u_step (
		.cp   (cp_s1),
		.sep  (sep_q),
		.mode (mode_q),
		.acc  (acc_q),
		.hcnt (hcnt_q),
		.res  (step)
	);

	csv_tok_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (proc),
		.nres      (step.nres),
		.r0        (step.r0),
		.r1        (step.r1),
		.room      (room),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.head      (head)
	);

	assign token_kind  = head.kind;
	assign char_value  = head.value;
	assign last_of_run = head.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sep_q  <= SEP_RESET;
			mode_q <= MODE_START;
			acc_q  <= '0;
			hcnt_q <= '0;
		end else begin
			if (take)
				vld_s1 <= 1'b1;
			else if (proc)
				vld_s1 <= 1'b0;
			if (cfg_valid && cfg_ready)
				sep_q <= separator_char;
			if (proc) begin
				mode_q <= step.mode;
				acc_q  <= step.acc;
				hcnt_q <= step.hcnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cp_s1 <= code_point;
	end

	`CSV_TOK_ASSERT_NEXT(a_error_sticky, mode_q == MODE_ERROR, mode_q == MODE_ERROR, "error mode left")
	`CSV_TOK_ASSERT(a_hcnt_in_hex, hcnt_q != '0, mode_q == MODE_HEX || mode_q == MODE_ERROR, "hex count outside hex mode")
	`CSV_TOK_ASSERT_NEXT(a_run_follows, tok_valid && !tok_stall && !last_of_run, tok_valid, "second word of a run missing")

endmodule

// ===== src/csv_tok_step.sv =====
// ----------------------------------------------------------------------------
// csv_tok_step
// Next-state and result decode for one code point in the current mode.
// ----------------------------------------------------------------------------
module csv_tok_step import csv_tok_pkg::*; (
	input  logic [CP_W-1:0]   cp,
	input  logic [CP_W-1:0]   sep,
	input  logic [MODE_W-1:0] mode,
	input  logic [ACC_W-1:0]  acc,
	input  logic [HCNT_W-1:0] hcnt,
	output step_res_t         res
);

	start_res_t        st;
	logic [4:0]        hd;
	logic [ACC_W-1:0]  acc_nx;
	logic [NRES_W-1:0] n;
	tok_res_t          a;
	tok_res_t          b;
	logic [MODE_W-1:0] m;
	logic [ACC_W-1:0]  ac;
	logic [HCNT_W-1:0] hc;

	always_comb begin
		st     = start_step(cp, sep);
		hd     = hex_digit(cp);
		acc_nx = {acc[ACC_W-5:0], hd[3:0]};
		n      = 2'd0;
		a      = '{kind: KIND_CHAR, value: '0, last: 1'b0};
		b      = '{kind: KIND_CHAR, value: '0, last: 1'b1};
		m      = mode;
		ac     = acc;
		hc     = hcnt;
		case (mode)
			MODE_START: begin
				a = '{kind: st.kind, value: cp, last: 1'b0};
				n = {1'b0, st.emit};
				m = st.mode;
			end
			MODE_LITERAL: begin
				if (is_lit_term(cp)) begin
					a = '{kind: KIND_END, value: '0, last: 1'b0};
					b = '{kind: st.kind, value: cp, last: 1'b1};
					n = st.emit ? 2'd2 : 2'd1;
					m = st.mode;
				end else begin
					a = '{kind: KIND_CHAR, value: cp, last: 1'b0};
					n = 2'd1;
				end
			end
			MODE_STRING: begin
				if (cp == CH_DQUOTE) begin
					a = '{kind: KIND_END, value: '0, last: 1'b0};
					n = 2'd1;
					m = MODE_START;
				end else if (cp == CH_BSLASH) begin
					m = MODE_ESCAPE;
				end else begin
					a = '{kind: KIND_CHAR, value: cp, last: 1'b0};
					n = 2'd1;
				end
			end
			MODE_ESCAPE: begin
				m = MODE_STRING;
				n = 2'd1;
				if (cp == CH_DQUOTE || cp == CH_BSLASH || cp == CH_SLASH)
					a.value = cp;
				else if (cp == CH_B)
					a.value = CH_BS_CTL;
				else if (cp == CH_F)
					a.value = CH_FF;
				else if (cp == CH_N)
					a.value = CH_LF;
				else if (cp == CH_R)
					a.value = CH_CR;
				else if (cp == CH_T)
					a.value = CH_TAB;
				else begin
					n = 2'd0;
					if (cp == CH_U) begin
						ac = '0;
						hc = '0;
						m  = MODE_HEX;
					end
				end
			end
			MODE_HEX: begin
				if (!hd[4]) begin
					a = '{kind: KIND_ERROR, value: '0, last: 1'b0};
					n = 2'd1;
					m = MODE_ERROR;
				end else if (hcnt == 3'd3) begin
					a  = '{kind: KIND_CHAR, value: CP_W'(acc_nx), last: 1'b0};
					n  = 2'd1;
					ac = acc_nx;
					hc = '0;
					m  = MODE_STRING;
				end else begin
					ac = acc_nx;
					hc = hcnt + 3'd1;
				end
			end
			MODE_SEP: begin
				if (cp == sep) begin
					a = '{kind: KIND_EMPTY, value: '0, last: 1'b0};
					b = '{kind: KIND_SEP, value: cp, last: 1'b1};
					n = 2'd2;
				end else begin
					a = '{kind: st.kind, value: cp, last: 1'b0};
					n = {1'b0, st.emit};
					m = st.mode;
				end
			end
			MODE_EOL: begin
				if (!is_eol(cp)) begin
					a = '{kind: st.kind, value: cp, last: 1'b0};
					n = {1'b0, st.emit};
					m = st.mode;
				end
			end
			default: begin
				a = '{kind: KIND_ERROR, value: '0, last: 1'b0};
				n = 2'd1;
				m = MODE_ERROR;
			end
		endcase
		a.last   = (n == 2'd1);
		res.mode = m;
		res.acc  = ac;
		res.hcnt = hc;
		res.nres = n;
		res.r0   = a;
		res.r1   = b;
	end

endmodule

// ===== src/csv_tok_obuf.sv =====
// ----------------------------------------------------------------------------
// csv_tok_obuf
// Two-entry result buffer; up to two words in, one out per unstalled cycle.
// ----------------------------------------------------------------------------
module csv_tok_obuf import csv_tok_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [NRES_W-1:0] nres,
	input  tok_res_t          r0,
	input  tok_res_t          r1,
	output logic [NRES_W-1:0] room,
	output logic              tok_valid,
	input  logic              tok_stall,
	output tok_res_t          head
);

	tok_res_t          e0_q;
	tok_res_t          e1_q;
	logic [1:0]        cnt_q;
	logic              pop;
	logic [1:0]        base;
	logic [1:0]        add;
	tok_res_t          e0_nx;
	tok_res_t          e1_nx;

	assign tok_valid = (cnt_q != 2'd0);
	assign head      = e0_q;
	assign pop       = tok_valid && !tok_stall;
	assign base      = cnt_q - {1'b0, pop};
	assign room      = 2'd2 - base;
	assign add       = push ? nres : 2'd0;

	always_comb begin
		e0_nx = pop ? e1_q : e0_q;
		e1_nx = e1_q;
		case (base)
			2'd0: begin
				e0_nx = r0;
				e1_nx = r1;
			end
			2'd1: begin
				e1_nx = r0;
			end
			default: begin
				e1_nx = e1_q;
			end
		endcase
		if (add == 2'd0) begin
			e0_nx = pop ? e1_q : e0_q;
			e1_nx = e1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + add;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_nx;
		e1_q <= e1_nx;
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CSV code point tokenizer. Opening sequence
// touches each mode but error and the \n, \u and unknown escapes; random CSV
// records with noise run under a range of separator settings, and a bad hex
// digit ends in sticky error mode. A scoreboard predicts each word in order.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import csv_tok_pkg::*;

	localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
	localparam logic [CP_W-1:0] CH_DIG0 = 21'd48;
	localparam logic [CP_W-1:0] CH_DIG9 = 21'd57;
	localparam logic [CP_W-1:0] CH_SEMI = 21'd59;
	localparam logic [CP_W-1:0] CH_A_UP = 21'd65;
	localparam logic [CP_W-1:0] CH_F_UP = 21'd70;
	localparam logic [CP_W-1:0] CH_A_LO = 21'd97;
	localparam logic [CP_W-1:0] CH_Q    = 21'd113;
	localparam logic [CP_W-1:0] CH_X    = 21'd120;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 220;

	class tok_scoreboard;
		logic [CP_W-1:0]   sep;
		logic [MODE_W-1:0] mode;
		logic [ACC_W-1:0]  acc;
		logic [HCNT_W-1:0] hcnt;
		tok_res_t          expected_words[$];
		tok_res_t          burst[$];
		int                errors;
		int                checked;
		int                kind_seen[6];

		function new();
			sep = SEP_RESET;
			mode = MODE_START;
			acc = '0;
			hcnt = '0;
			errors = 0;
			checked = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
		endfunction

		function bit digit_of(input logic [CP_W-1:0] cp, output logic [3:0] nib);
			nib = 4'd0;
			if (cp >= CH_DIG0 && cp <= CH_DIG9) begin
				nib = 4'(cp - CH_DIG0);
				return 1'b1;
			end
			if (cp >= CH_A_LO && cp <= CH_F) begin
				nib = 4'(cp - CH_A_LO + 21'd10);
				return 1'b1;
			end
			if (cp >= CH_A_UP && cp <= CH_F_UP) begin
				nib = 4'(cp - CH_A_UP + 21'd10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void put(input logic [KIND_W-1:0] kind, input logic [CP_W-1:0] value);
			tok_res_t w;
			w.kind = kind;
			w.value = value;
			w.last = 1'b0;
			if (burst.size() < 2)
				burst.insert(burst.size(), w);
		endfunction

		// returns 1 when the code point must be handled again in start mode
		function bit decode_once(input logic [CP_W-1:0] cp);
			bit again;
			logic [3:0] nib;
			again = 1'b0;
			case (mode)
			MODE_START: begin
				if (cp == sep) begin
					put(KIND_SEP, cp);
					mode = MODE_SEP;
				end else if (cp == CH_SPACE || cp == CH_TAB) begin
					// skip blanks
				end else if (cp == CH_LF || cp == CH_CR) begin
					put(KIND_EOL, cp);
					mode = MODE_EOL;
				end else if (cp == CH_DQUOTE) begin
					mode = MODE_STRING;
				end else begin
					put(KIND_CHAR, cp);
					mode = MODE_LITERAL;
				end
			end
			MODE_LITERAL: begin
				case (cp)
				CH_LF, CH_CR, CH_DQUOTE, CH_SQUOTE, CH_LBRACK, CH_RBRACK,
				CH_LBRACE, CH_RBRACE, CH_COMMA, CH_COLON: begin
					put(KIND_END, '0);
					mode = MODE_START;
					again = 1'b1;
				end
				default: put(KIND_CHAR, cp);
				endcase
			end
			MODE_STRING: begin
				if (cp == CH_DQUOTE) begin
					put(KIND_END, '0);
					mode = MODE_START;
				end else if (cp == CH_BSLASH) begin
					mode = MODE_ESCAPE;
				end else begin
					put(KIND_CHAR, cp);
				end
			end
			MODE_ESCAPE: begin
				mode = MODE_STRING;
				case (cp)
				CH_DQUOTE, CH_BSLASH, CH_SLASH: put(KIND_CHAR, cp);
				CH_B: put(KIND_CHAR, CH_BS_CTL);
				CH_F: put(KIND_CHAR, CH_FF);
				CH_N: put(KIND_CHAR, CH_LF);
				CH_R: put(KIND_CHAR, CH_CR);
				CH_T: put(KIND_CHAR, CH_TAB);
				CH_U: begin
					acc = '0;
					hcnt = '0;
					mode = MODE_HEX;
				end
				default: begin
					// drop unknown escapes
				end
				endcase
			end
			MODE_HEX: begin
				if (!digit_of(cp, nib)) begin
					put(KIND_ERROR, '0);
					mode = MODE_ERROR;
				end else begin
					acc = {acc[ACC_W-5:0], nib};
					hcnt = hcnt + 1'b1;
					if (hcnt >= 3'd4) begin
						put(KIND_CHAR, {5'd0, acc});
						hcnt = '0;
						mode = MODE_STRING;
					end
				end
			end
			MODE_SEP: begin
				if (cp == sep) begin
					put(KIND_EMPTY, '0);
					put(KIND_SEP, cp);
				end else begin
					mode = MODE_START;
					again = 1'b1;
				end
			end
			MODE_EOL: begin
				if (cp != CH_LF && cp != CH_CR) begin
					mode = MODE_START;
					again = 1'b1;
				end
			end
			default: begin
				put(KIND_ERROR, '0);
				mode = MODE_ERROR;
			end
			endcase
			return again;
		endfunction

		function void note_code_point(input logic [CP_W-1:0] cp);
			int pass;
			burst.delete();
			for (pass = 0; pass < 3; pass++)
				if (!decode_once(cp)) break;
			if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
			foreach (burst[i]) expected_words.insert(expected_words.size(), burst[i]);
		endfunction

		function void check_word(input logic [KIND_W-1:0] kind, input logic [CP_W-1:0] value,
				input logic last);
			tok_res_t want;
			if (expected_words.size() == 0) begin
				$error("unexpected word: token_kind %0d char_value %0h last_of_run %0b",
					kind, value, last);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			checked++;
			if (want.kind < 6) kind_seen[want.kind]++;
			if (kind !== want.kind) begin
				$error("token_kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (value !== want.value) begin
				$error("char_value: expected %0h, got %0h", want.value, value);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_run: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cp_valid = 1'b0;
	logic            cp_stall;
	logic [CP_W-1:0] code_point = '0;
	logic            tok_valid;
	logic            tok_stall = 1'b0;
	logic [KIND_W-1:0] token_kind;
	logic [CP_W-1:0] char_value;
	logic            last_of_run;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [CP_W-1:0] separator_char = SEP_RESET;

	tok_scoreboard   sb = new();
	logic [CP_W-1:0] text[$];
	bit              calm = 1'b0;
	int              items = 0;
	int              sep_writes = 0;
	int              stall_left = 0;
	int              quiet = 0;

	logic [CP_W-1:0] opening[25] = '{CP_MAX, CH_COMMA, CH_COMMA, CH_SPACE, CH_TAB, 21'd0,
		CH_COLON, CH_DQUOTE, CH_BSLASH, CH_N, CH_BSLASH, CH_U, CH_A_UP, CH_F, CH_DIG0,
		CH_DIG9, CH_BSLASH, CH_Q, CH_DQUOTE, CH_CR, CH_LF, CH_DQUOTE, CH_DQUOTE, CH_X,
		CH_LF};
	logic [CP_W-1:0] marks[16] = '{CH_COLON, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
		CH_SQUOTE, CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_DQUOTE, CH_COMMA, CH_SLASH,
		CH_BSLASH, CH_U, CP_MAX};
	logic [CP_W-1:0] sep_plan[7] = '{CH_SEMI, CH_TAB, 21'd0, CP_MAX, CH_SPACE,
		21'h0F5A3C, CH_COMMA};

	csv_code_point_tokenizer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cp_valid       (cp_valid),
		.cp_stall       (cp_stall),
		.code_point     (code_point),
		.tok_valid      (tok_valid),
		.tok_stall      (tok_stall),
		.token_kind     (token_kind),
		.char_value     (char_value),
		.last_of_run    (last_of_run),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.separator_char (separator_char)
	);

	always #5 clk = ~clk;

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && !tok_stall) begin
				sb.check_word(token_kind, char_value, last_of_run);
				stall_left = draw_wait();
				if (stall_left > 0) tok_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0) tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cp_valid && !cp_stall) || (tok_valid && !tok_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic void append_cp(input logic [CP_W-1:0] cp);
		text.insert(text.size(), cp);
	endfunction

	function automatic logic [CP_W-1:0] pick_hex();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return CP_W'(CH_DIG0 + r);
		if (r < 16) return CP_W'(CH_A_LO + r - 10);
		return CP_W'(CH_A_UP + r - 16);
	endfunction

	function automatic logic [CP_W-1:0] pick_plain();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return CP_W'(CH_A_LO + $urandom_range(0, 25));
		4: return CP_W'(CH_A_UP + $urandom_range(0, 25));
		5: return CP_W'(CH_DIG0 + $urandom_range(0, 9));
		6, 7: return CP_W'($urandom_range(0, CP_MAX));
		8: return CP_W'($urandom_range(128, 21'h7FF));
		default: return CP_W'($urandom_range(21'h10000, CP_MAX));
		endcase
	endfunction

	function automatic logic [CP_W-1:0] pick_any();
		int r;
		r = $urandom_range(0, 33);
		if (r < 16) return marks[r];
		if (r == 16) return sb.sep;
		return CP_W'($urandom_range(0, CP_MAX));
	endfunction

	// keep a \u escape well-formed so the error mode is only reached on purpose
	function automatic logic [CP_W-1:0] keep_legal(input logic [CP_W-1:0] cp);
		logic [3:0] nib;
		if (sb.mode == MODE_HEX && !sb.digit_of(cp, nib)) return pick_hex();
		return cp;
	endfunction

	function automatic void add_escape();
		append_cp(CH_BSLASH);
		case ($urandom_range(0, 9))
		0: append_cp(CH_DQUOTE);
		1: append_cp(CH_BSLASH);
		2: append_cp(CH_SLASH);
		3: append_cp(CH_B);
		4: append_cp(CH_F);
		5: append_cp(CH_N);
		6: append_cp(CH_R);
		7: append_cp(CH_T);
		8: begin
			append_cp(CH_U);
			repeat (4) append_cp(pick_hex());
		end
		default: append_cp($urandom_range(0, 1) ? CH_Q : pick_plain());
		endcase
	endfunction

	function automatic void add_field();
		int shape;
		shape = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) append_cp($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		if (shape == 0) return;
		if (shape <= 4) begin
			repeat ($urandom_range(1, 6)) append_cp(pick_plain());
			if ($urandom_range(0, 7) == 0) begin
				append_cp(marks[$urandom_range(0, 5)]);
				append_cp(pick_plain());
			end
		end else if (shape <= 8) begin
			append_cp(CH_DQUOTE);
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 2) == 0) add_escape();
				else append_cp(pick_plain());
			end
			append_cp(CH_DQUOTE);
			if ($urandom_range(0, 4) == 0) append_cp(CH_SPACE);
		end else begin
			repeat ($urandom_range(1, 4)) append_cp(pick_any());
		end
	endfunction

	function automatic void add_record();
		int fields;
		if ($urandom_range(0, 6) == 0) begin
			repeat ($urandom_range(1, 8)) append_cp(pick_any());
			return;
		end
		fields = $urandom_range(1, 5);
		for (int i = 0; i < fields; i++) begin
			add_field();
			if (i < fields - 1) append_cp(sb.sep);
		end
		case ($urandom_range(0, 3))
		0: append_cp(CH_LF);
		1: append_cp(CH_CR);
		2: begin
			append_cp(CH_CR);
			append_cp(CH_LF);
		end
		default: begin
			append_cp(CH_LF);
			append_cp(CH_LF);
		end
		endcase
	endfunction

	task automatic send_cp(input logic [CP_W-1:0] cp);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			cp_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cp_valid <= 1'b1;
		code_point <= cp;
		@(posedge clk);
		while (cp_stall) @(posedge clk);
		sb.note_code_point(cp);
		items++;
		if (items % 50 == 0) calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic play_text();
		foreach (text[i]) send_cp(keep_legal(text[i]));
		text.delete();
	endtask

	task automatic random_phase(input int count);
		int first;
		first = items;
		while (items - first < count) begin
			add_record();
			play_text();
		end
	endtask

	// drain every expected word, then let the pipeline empty
	task automatic settle();
		cp_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_separator(input logic [CP_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		separator_char <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.sep = value;
		sep_writes++;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i]) send_cp(opening[i]);
		random_phase(PHASE_ITEMS);
		foreach (sep_plan[i]) begin
			write_separator(sep_plan[i]);
			random_phase(PHASE_ITEMS);
		end

		// steer into a \u escape, then break it with a bad digit
		while (sb.mode != MODE_HEX) begin
			case (sb.mode)
			MODE_STRING: send_cp(CH_BSLASH);
			MODE_ESCAPE: send_cp(CH_U);
			default: send_cp(CH_DQUOTE);
			endcase
		end
		send_cp(CH_COLON);
		repeat (4) send_cp(CP_W'($urandom_range(0, CP_MAX)));

		cp_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Run: %0d code points, %0d words checked, %0d separator writes",
			items, sb.checked, sep_writes);
		$display("Words by kind: char %0d, end %0d, empty %0d, sep %0d, eol %0d, error %0d",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
			sb.kind_seen[4], sb.kind_seen[5]);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
